/* hw/rtl/arsr_pkg.sv */
// arsr_pkg: shared types and constants of the aspect ratio to SAR reducer.
// Holds field widths, the case codes and the control/status structs that
// join the controller and the datapath. No dependencies.
`default_nettype none

package arsr_pkg;

    // Field widths
    localparam int AspW   = 17;
    localparam int FrameW = 14;
    localparam int SarW   = 30;
    localparam int ShiftW = 5;

    // Slack of the near-square test is 16 * dar_h, a left shift by four
    localparam int SlackShift = 4;
    localparam int SlackW     = AspW + SlackShift;

    // Case codes on case_code
    typedef enum logic [1:0] {
        CODE_INVALID = 2'd0,
        CODE_DISPLAY = 2'd1,
        CODE_SQUARE  = 2'd2,
        CODE_SAMPLE  = 2'd3
    } case_code_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture the input beat
        logic mul;        // form the two operands (products or plain terms)
        logic test;       // classify, preset result, seed the gcd unit
        logic gcd_step;   // one binary gcd step, or capture g when finished
        logic div_start;  // launch the serial divider
        logic div_sel_y;  // divide y instead of x
        logic store_w;    // capture quotient as result width
        logic store_h;    // capture quotient as result height
        logic publish;    // move the result into the output register
    } arsr_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic invalid;    // opposite signs or a zero term
        logic near_sq;    // display ratio within the near-square slack
        logic gcd_done;   // one gcd operand has reached zero
        logic div_done;   // divider quotient ready this cycle
    } arsr_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/aspect_ratio_to_sar_reducer.sv */
// aspect_ratio_to_sar_reducer: top level, joins controller and datapath.
// Depends on arsr_pkg, arsr_ctrl, arsr_dp (which holds arsr_div).
//
//   Channel  Handshake             Payload
//   in       in_valid / in_ready   aspect_w_in, aspect_h_in, frame_width,
//                                  frame_height
//   out      out_valid / out_ready sar_w_out, sar_h_out, case_code
//
// One item at a time. Invalid and near-square items go from accept through the
// multiply and test states to publish; reduced items also run the binary gcd
// unit, which latches g once an operand reaches zero, and then the serial
// divider twice, once per quotient, before the result is published.
// Reset (rst_n low) clears the sequencer, the divider and the output valid.
// A new beat is accepted while a finished result waits at the output; the
// next result is held until that beat is taken.
`default_nettype none

module aspect_ratio_to_sar_reducer
    import arsr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [AspW-1:0]   aspect_w_in,
    input  wire logic [AspW-1:0]   aspect_h_in,
    input  wire logic [FrameW-1:0] frame_width,
    input  wire logic [FrameW-1:0] frame_height,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [SarW-1:0]        sar_w_out,
    output logic [SarW-1:0]        sar_h_out,
    output logic [1:0]             case_code
);

    arsr_cmd_t  cmd;
    arsr_stat_t stat;

    // Sequencer and handshakes
    arsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Arithmetic and result registers
    arsr_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .aspect_w_in  (aspect_w_in),
        .aspect_h_in  (aspect_h_in),
        .frame_width  (frame_width),
        .frame_height (frame_height),
        .sar_w_out    (sar_w_out),
        .sar_h_out    (sar_h_out),
        .case_code    (case_code)
    );

endmodule

`default_nettype wire

/* hw/rtl/arsr_div.sv */
// arsr_div: restoring serial divider, one quotient bit per cycle.
// Used twice per reduced item to divide x and y by their gcd. Depends on arsr_pkg.
`default_nettype none

module arsr_div
    import arsr_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [SarW-1:0] dividend,
    input  wire logic [SarW-1:0] divisor,
    output logic                 done,
    output logic [SarW-1:0]      quotient
);

    localparam int CntW = $clog2(SarW);
    localparam logic [CntW-1:0] LastStep = CntW'(SarW - 1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic [SarW-1:0] rem_reg, rem_next;
    logic [SarW-1:0] quo_reg, quo_next;
    logic [SarW-1:0] dvs_reg, dvs_next;

    logic [SarW:0]   shifted;
    logic [SarW:0]   trial;

    // Shift in the next dividend bit and try to subtract the divisor
    assign shifted = {rem_reg, quo_reg[SarW-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // Keep the difference when it did not borrow
            if (!trial[SarW])
            begin
                rem_next = trial[SarW-1:0];
                quo_next = {quo_reg[SarW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[SarW-1:0];
                quo_next = {quo_reg[SarW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CntW'(1);
            if (cnt_reg == LastStep)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operands and partial results
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    // Never relaunch while a division is in flight
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    // Completion follows a busy cycle
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");

endmodule

`default_nettype wire

/* hw/rtl/arsr_dp.sv */
// arsr_dp: datapath of the reducer: input capture, products, near-square
// test, binary gcd unit, serial divider and result registers.
// Depends on arsr_pkg and arsr_div.
`default_nettype none

module arsr_dp
    import arsr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire arsr_cmd_t         cmd,
    output arsr_stat_t             stat,
    input  wire logic [AspW-1:0]   aspect_w_in,
    input  wire logic [AspW-1:0]   aspect_h_in,
    input  wire logic [FrameW-1:0] frame_width,
    input  wire logic [FrameW-1:0] frame_height,
    output logic [SarW-1:0]        sar_w_out,
    output logic [SarW-1:0]        sar_h_out,
    output logic [1:0]             case_code
);

    localparam int ProdW = AspW + FrameW;

    // Captured beat
    logic [AspW-1:0]   aw_reg, ah_reg;
    logic [FrameW-1:0] fw_reg, fh_reg;

    // Operands, gcd state, result and output registers
    logic [SarW-1:0]   x_reg, y_reg;
    logic [SarW-1:0]   a_reg, a_next;
    logic [SarW-1:0]   b_reg, b_next;
    logic [ShiftW-1:0] k_reg, k_next;
    logic [SarW-1:0]   g_reg;
    logic [SarW-1:0]   res_w_reg, res_h_reg;
    case_code_t        code_reg;
    logic [SarW-1:0]   sar_w_reg, sar_h_reg;
    case_code_t        sar_code_reg;

    logic            display;
    logic [AspW-1:0] dw, dh;
    logic [ProdW-1:0] prod_x, prod_y;
    logic [SarW-1:0] xy_diff;
    logic [SlackW-1:0] slack;
    logic            near_sq;
    logic [SarW:0]   a_sub_b;
    logic [SarW-1:0] gcd_nz;
    logic [SarW-1:0] gcd_val;
    logic            gcd_done;
    logic            div_done;
    logic [SarW-1:0] div_q;
    logic [SarW-1:0] div_dividend;
    logic [SarW:0]   ab_sum;

    // Classify the sign pair
    assign display = aw_reg[AspW-1];
    assign stat.invalid = (aw_reg == '0) || (ah_reg == '0)
                          || (aw_reg[AspW-1] != ah_reg[AspW-1]);

    // Display terms as magnitudes; the most negative code maps to 2^16
    assign dw = ~aw_reg + AspW'(1);
    assign dh = ~ah_reg + AspW'(1);

    // Cross products of display ratio and frame size
    assign prod_x = ProdW'(dw) * ProdW'(fh_reg);
    assign prod_y = ProdW'(dh) * ProdW'(fw_reg);

    // Near-square test: |y - x| against 16 * dar_h
    assign xy_diff = (y_reg >= x_reg) ? (y_reg - x_reg) : (x_reg - y_reg);
    assign slack   = {dh, {SlackShift{1'b0}}};
    assign near_sq = display && (xy_diff <= SarW'(slack));
    assign stat.near_sq = near_sq;

    // Binary gcd: one operand at zero ends the search
    assign gcd_done = (a_reg == '0) || (b_reg == '0);
    assign stat.gcd_done = gcd_done;
    assign a_sub_b  = {1'b0, a_reg} - {1'b0, b_reg};
    assign gcd_nz   = (a_reg | b_reg) << k_reg;
    assign gcd_val  = (gcd_nz == '0) ? SarW'(1) : gcd_nz;
    assign ab_sum   = {1'b0, a_reg} + {1'b0, b_reg};

    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        k_next = k_reg;
        priority if (!a_reg[0] && !b_reg[0])
        begin
            a_next = a_reg >> 1;
            b_next = b_reg >> 1;
            k_next = k_reg + ShiftW'(1);
        end
        else if (!a_reg[0])
        begin
            a_next = a_reg >> 1;
        end
        else if (!b_reg[0])
        begin
            b_next = b_reg >> 1;
        end
        else if (!a_sub_b[SarW])
        begin
            a_next = a_sub_b[SarW:1];
        end
        else
        begin
            b_next = SarW'((b_reg - a_reg) >> 1);
        end
    end

    // Shared serial divider
    assign div_dividend = cmd.div_sel_y ? y_reg : x_reg;

    arsr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (g_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign stat.div_done = div_done;

    // Payload registers, advanced by controller commands
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            aw_reg <= aspect_w_in;
            ah_reg <= aspect_h_in;
            fw_reg <= frame_width;
            fh_reg <= frame_height;
        end
        if (cmd.mul)
        begin
            if (display)
            begin
                x_reg <= prod_x[SarW-1:0];
                y_reg <= prod_y[SarW-1:0];
            end
            else
            begin
                x_reg <= SarW'(aw_reg);
                y_reg <= SarW'(ah_reg);
            end
        end
        if (cmd.test)
        begin
            a_reg <= x_reg;
            b_reg <= y_reg;
            k_reg <= '0;
            priority if (stat.invalid)
            begin
                code_reg  <= CODE_INVALID;
                res_w_reg <= '0;
                res_h_reg <= '0;
            end
            else if (near_sq)
            begin
                code_reg  <= CODE_SQUARE;
                res_w_reg <= SarW'(1);
                res_h_reg <= SarW'(1);
            end
            else if (display)
            begin
                code_reg <= CODE_DISPLAY;
            end
            else
            begin
                code_reg <= CODE_SAMPLE;
            end
        end
        if (cmd.gcd_step)
        begin
            if (gcd_done)
            begin
                g_reg <= gcd_val;
            end
            else
            begin
                a_reg <= a_next;
                b_reg <= b_next;
                k_reg <= k_next;
            end
        end
        if (cmd.store_w)
        begin
            res_w_reg <= div_q;
        end
        if (cmd.store_h)
        begin
            res_h_reg <= div_q;
        end
        if (cmd.publish)
        begin
            sar_w_reg    <= res_w_reg;
            sar_h_reg    <= res_h_reg;
            sar_code_reg <= code_reg;
        end
    end

    assign sar_w_out = sar_w_reg;
    assign sar_h_out = sar_h_reg;
    assign case_code = sar_code_reg;

    // Every gcd step strictly shrinks a + b
    a_gcd_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.gcd_step && !gcd_done) |=> (ab_sum < $past(ab_sum)))
        else $error("gcd step did not make progress");

endmodule

`default_nettype wire

/* hw/rtl/arsr_ctrl.sv */
// arsr_ctrl: sequencer of the reducer and owner of the handshakes.
// Steps the datapath through capture, operands, test and, for reduced items, gcd and two divisions.
// Depends on arsr_pkg.
`default_nettype none

module arsr_ctrl
    import arsr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire arsr_stat_t stat,
    output arsr_cmd_t       cmd
);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_MUL     = 9'b000000010,
        S_TEST    = 9'b000000100,
        S_GCD     = 9'b000001000,
        S_DIVX_GO = 9'b000010000,
        S_DIVX    = 9'b000100000,
        S_DIVY_GO = 9'b001000000,
        S_DIVY    = 9'b010000000,
        S_DONE    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    // Output register can take a result this cycle
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_TEST;
            end
            S_TEST:
            begin
                cmd.test = 1'b1;
                if (stat.invalid || stat.near_sq)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_GCD;
                end
            end
            S_GCD:
            begin
                cmd.gcd_step = 1'b1;
                if (stat.gcd_done)
                begin
                    state_next = S_DIVX_GO;
                end
            end
            S_DIVX_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIVX;
            end
            S_DIVX:
            begin
                if (stat.div_done)
                begin
                    cmd.store_w = 1'b1;
                    state_next  = S_DIVY_GO;
                end
            end
            S_DIVY_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel_y = 1'b1;
                state_next    = S_DIVY;
            end
            S_DIVY:
            begin
                if (stat.div_done)
                begin
                    cmd.store_h = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                // Hold the result until the output register frees up
                if (out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output beat valid: set on publish, drop once taken
    always_comb
    begin
        priority if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // A publish never overwrites a beat still waiting at the output
    a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> (!out_valid_reg || out_ready))
        else $error("result published over a pending output beat");

    // Divider completions arrive only while a division is awaited
    a_div_expected: assert property (@(posedge clk) disable iff (!rst_n)
        stat.div_done |-> (state_reg == S_DIVX || state_reg == S_DIVY))
        else $error("divider done outside a division wait");

endmodule

`default_nettype wire
